// File: rtl/core/tmdm_pkg.sv
// Shared constants, types and codes for the trimmed mean block.
package tmdm_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int STATUS_W        = 2;
	localparam int MAX_SAMPLES_DEF = 256;
	localparam int MIN_BATCH       = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_TOO_FEW  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_DIVIDE,
		S_DELIVER
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
	} div_stat_t;

endpackage

// File: rtl/core/tmdm_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
interface tmdm_in_if;
	logic                          valid;
	logic                          ready;
	logic [tmdm_pkg::SAMPLE_W-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface tmdm_out_if;
	logic                          valid;
	logic                          ready;
	logic [tmdm_pkg::SAMPLE_W-1:0] average;
	logic [tmdm_pkg::STATUS_W-1:0] status;

	modport source (output valid, output average, output status, input ready);
	modport sink   (input valid, input average, input status, output ready);
endinterface

// File: rtl/core/tmdm_div.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
module tmdm_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmdm_pkg::div_ctrl_t   ctrl,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output tmdm_pkg::div_stat_t   stat,
	output logic [NUM_W-1:0]      quotient
);
	import tmdm_pkg::*;

	localparam int ITER_W = $clog2(NUM_W + 1);

	logic [ITER_W-1:0] iter_q;
	logic [NUM_W-1:0]  work_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  diff;
	logic              ge;

	// Bring down the next dividend bit and try to subtract the divisor.
	always_comb begin
		shifted = {rem_q, work_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		ge      = !diff[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (ctrl.start) begin
			iter_q <= ITER_W'(NUM_W);
		end else if (iter_q != '0) begin
			iter_q <= iter_q - ITER_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (iter_q != '0) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign stat.busy = (iter_q != '0);
	assign quotient  = work_q;

endmodule

// File: rtl/core/trimmed_mean_drop_min_max.sv
// Trimmed mean: while idle, samples are accepted one per cycle; a last sample stops input until
// its result is handed off. Samples that are not last are folded into the batch at once.
// A last sample starts the division: a setup state, then the restoring divider (one quotient bit
// per cycle), then a hand-off state. A batch under MIN_BATCH samples skips the divider.
// The result sits in an output register, so a waiting result does not block new samples; only
// the next last sample waits in the hand-off state until that register is free.
// Reset (arst_n low, asynchronous) empties the batch and the output register.
module trimmed_mean_drop_min_max #(
	parameter int MAX_SAMPLES = tmdm_pkg::MAX_SAMPLES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tmdm_in_if.sink    samples,
	tmdm_out_if.source results
);
	import tmdm_pkg::*;

	// The count must hold MAX_SAMPLES itself; the sum must hold MAX_SAMPLES full-scale samples.
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_W + CNT_W;

	state_t                state_q, state_d;

	// Batch accumulators.
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SAMPLE_W-1:0]   min_q;
	logic [SAMPLE_W-1:0]   max_q;
	logic                  ovf_q;

	// Status of the batch being finished.
	status_t               fin_status_q;

	// Output register.
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   out_average_q;
	status_t               out_status_q;

	logic                  in_fire;
	logic                  has_room;
	logic                  too_few;
	logic                  load_out;
	div_ctrl_t             div_ctrl;
	div_stat_t             div_stat;
	logic [SUM_W-1:0]      dividend;
	logic [CNT_W-1:0]      divisor;
	logic [SUM_W-1:0]      quotient;

	assign in_fire  = samples.valid && samples.ready;
	assign has_room = (cnt_q < CNT_W'(MAX_SAMPLES));
	assign too_few  = (cnt_q < CNT_W'(MIN_BATCH));

	// Drop exactly one minimum and one maximum. With at least three samples the sum
	// always covers both, so the subtraction cannot wrap.
	assign dividend = sum_q - SUM_W'(min_q) - SUM_W'(max_q);
	assign divisor  = cnt_q - CNT_W'(2);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && samples.last) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				// A short batch needs no division; its average is simply zero.
				state_d = too_few ? S_DELIVER : S_DIVIDE;
			end
			S_DIVIDE: begin
				if (!div_stat.busy) begin
					state_d = S_DELIVER;
				end
			end
			S_DELIVER: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output and control decode.
	always_comb begin
		samples.ready  = 1'b0;
		div_ctrl.start = 1'b0;
		load_out       = 1'b0;
		case (state_q)
			S_IDLE: begin
				samples.ready = 1'b1;
			end
			S_PREP: begin
				div_ctrl.start = !too_few;
			end
			S_DIVIDE: begin
			end
			S_DELIVER: begin
				// Hand over only when the output register is empty or being emptied.
				load_out = !out_valid_q || results.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Batch accumulation. Once the batch is full, further samples only mark overflow.
	// Delivering a result returns the batch to its empty values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= '1;
			max_q <= '0;
			ovf_q <= 1'b0;
		end else if (load_out) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= '1;
			max_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_fire) begin
			if (has_room) begin
				sum_q <= sum_q + SUM_W'(samples.sample);
				cnt_q <= cnt_q + CNT_W'(1);
				if (samples.sample < min_q) begin
					min_q <= samples.sample;
				end
				if (samples.sample > max_q) begin
					max_q <= samples.sample;
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_status_q <= ST_OK;
		end else if (state_q == S_PREP) begin
			if (too_few) begin
				fin_status_q <= ST_TOO_FEW;
			end else if (ovf_q) begin
				fin_status_q <= ST_OVERFLOW;
			end else begin
				fin_status_q <= ST_OK;
			end
		end
	end

	// The trimmed mean never exceeds the largest sample, so the low bits hold it whole.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q  <= fin_status_q;
			out_average_q <= (fin_status_q == ST_TOO_FEW) ? '0 : quotient[SAMPLE_W-1:0];
		end
	end

	tmdm_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.num      (dividend),
		.den      (divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign results.valid   = out_valid_q;
	assign results.average = out_average_q;
	assign results.status  = out_status_q;

endmodule
